>>> rtl/core/ndem_pkg.sv
// ----------------------------------------------------------------------------
// ndem_pkg
// Shared constants, types and arithmetic helpers for the neighbor delta
// edge mask block.
// ----------------------------------------------------------------------------
package ndem_pkg;

	localparam int MAX_WIDTH_DEF = 4096;

	localparam int WIDTH_REG_W = 13;
	localparam int HEIGHT_W    = 16;
	localparam int THR_W       = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_X_W     = 12;
	localparam int PIX_W       = 32;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 2'd3;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = 13'd1920;
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = 16'd1080;
	localparam logic [THR_W-1:0]       THR_RST    = 8'd0;

	// result set queue
	localparam int QDEPTH = 8;
	localparam int QAW    = 3;
	localparam int QCW    = 4;

	// arithmetic pipeline depth and its occupancy count width
	localparam int PIPE_STAGES = 4;
	localparam int IFW         = 3;

	typedef struct packed {
		logic [OUT_X_W-1:0]  xa;
		logic [OUT_X_W-1:0]  xb;
		logic [HEIGHT_W-1:0] y;
		logic [HEIGHT_W-1:0] ya;
		logic                want_a;
		logic                want_b;
		logic                want_c;
		logic                use_right;
	} meta_t;

	typedef struct packed {
		logic [OUT_X_W-1:0]  xa;
		logic [OUT_X_W-1:0]  xb;
		logic [HEIGHT_W-1:0] y;
		logic [HEIGHT_W-1:0] ya;
		logic                want_a;
		logic                want_b;
		logic                want_c;
		logic                edge_a;
		logic                edge_b;
	} set_t;

	function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// floor(v / 255), exact for v up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	// floor(s / 3), exact for s up to 3 * 255
	function automatic logic [7:0] div3(input logic [9:0] s);
		logic [19:0] p;
		p = 20'(s) * 20'd683;
		return p[18:11];
	endfunction

endpackage

>>> rtl/core/ndem_line_buf.sv
// ----------------------------------------------------------------------------
// ndem_line_buf
// Single-port-write, single-port-read row memory with registered read data.
// ----------------------------------------------------------------------------
module ndem_line_buf #(
	parameter int DEPTH = ndem_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(ndem_pkg::MAX_WIDTH_DEF)
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [ndem_pkg::PIX_W-1:0]   wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [ndem_pkg::PIX_W-1:0]   rdata
);

	logic [ndem_pkg::PIX_W-1:0] row_mem_q [DEPTH];
	logic [ndem_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= row_mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ndem_diff.sv
// ----------------------------------------------------------------------------
// ndem_diff
// Four-stage difference pipeline: capture, premultiply, per-channel scaled
// abs difference, channel mean or alpha diff, threshold compare to result set.
// ----------------------------------------------------------------------------
module ndem_diff (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          alpha_mode,
	input  logic [ndem_pkg::THR_W-1:0]    threshold,
	input  logic                          start,
	input  logic [ndem_pkg::PIX_W-1:0]    cur,
	input  logic [ndem_pkg::PIX_W-1:0]    prev,
	input  logic [ndem_pkg::PIX_W-1:0]    above,
	input  ndem_pkg::meta_t               meta,
	input  logic [ndem_pkg::PIX_W-1:0]    right,
	output logic                          push,
	output ndem_pkg::set_t                push_set,
	output logic [ndem_pkg::IFW-1:0]      inflight
);

	logic                       v_s1, v_s2, v_s3, v_s4;
	ndem_pkg::meta_t            meta_s1, meta_s2, meta_s3, meta_s4;
	logic [ndem_pkg::PIX_W-1:0] cur_s1, prev_s1, above_s1;

	logic [15:0] pab_s2 [3];
	logic [15:0] prt_s2 [3];
	logic [15:0] pcu_s2 [3];
	logic [15:0] ppv_s2 [3];
	logic [7:0]  a_ab_s2, a_rt_s2, a_cu_s2, a_pv_s2;

	logic [7:0] q_ar_s3 [3];
	logic [7:0] q_ac_s3 [3];
	logic [7:0] q_pc_s3 [3];
	logic [7:0] ad_ar_s3, ad_ac_s3, ad_pc_s3;

	logic [7:0] d_ar_s4, d_ac_s4, d_pc_s4;

	logic [7:0] mv_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: capture pixels
	always_ff @(posedge clk) begin
		if (start) begin
			cur_s1   <= cur;
			prev_s1  <= prev;
			above_s1 <= above;
			meta_s1  <= meta;
		end
	end

	// stage 2: premultiplied channels
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			pab_s2[c] <= 16'(above_s1[8*c +: 8]) * 16'(above_s1[31:24]);
			prt_s2[c] <= 16'(right[8*c +: 8]) * 16'(right[31:24]);
			pcu_s2[c] <= 16'(cur_s1[8*c +: 8]) * 16'(cur_s1[31:24]);
			ppv_s2[c] <= 16'(prev_s1[8*c +: 8]) * 16'(prev_s1[31:24]);
		end
		a_ab_s2 <= above_s1[31:24];
		a_rt_s2 <= right[31:24];
		a_cu_s2 <= cur_s1[31:24];
		a_pv_s2 <= prev_s1[31:24];
		meta_s2 <= meta_s1;
	end

	// stage 3: scaled channel differences
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			q_ar_s3[c] <= ndem_pkg::div255(ndem_pkg::abs_diff16(pab_s2[c], prt_s2[c]));
			q_ac_s3[c] <= ndem_pkg::div255(ndem_pkg::abs_diff16(pab_s2[c], pcu_s2[c]));
			q_pc_s3[c] <= ndem_pkg::div255(ndem_pkg::abs_diff16(ppv_s2[c], pcu_s2[c]));
		end
		ad_ar_s3 <= ndem_pkg::abs_diff8(a_ab_s2, a_rt_s2);
		ad_ac_s3 <= ndem_pkg::abs_diff8(a_ab_s2, a_cu_s2);
		ad_pc_s3 <= ndem_pkg::abs_diff8(a_pv_s2, a_cu_s2);
		meta_s3  <= meta_s2;
	end

	// stage 4: channel mean or alpha difference
	always_ff @(posedge clk) begin
		if (alpha_mode) begin
			d_ar_s4 <= ad_ar_s3;
			d_ac_s4 <= ad_ac_s3;
			d_pc_s4 <= ad_pc_s3;
		end else begin
			d_ar_s4 <= ndem_pkg::div3(10'(q_ar_s3[0]) + 10'(q_ar_s3[1]) + 10'(q_ar_s3[2]));
			d_ac_s4 <= ndem_pkg::div3(10'(q_ac_s3[0]) + 10'(q_ac_s3[1]) + 10'(q_ac_s3[2]));
			d_pc_s4 <= ndem_pkg::div3(10'(q_pc_s3[0]) + 10'(q_pc_s3[1]) + 10'(q_pc_s3[2]));
		end
		meta_s4 <= meta_s3;
	end

	always_comb begin
		mv_a = d_ac_s4;
		if (meta_s4.use_right && (d_ar_s4 > d_ac_s4)) begin
			mv_a = d_ar_s4;
		end
	end

	assign push = v_s4 && (meta_s4.want_a || meta_s4.want_b || meta_s4.want_c);

	assign push_set.xa     = meta_s4.xa;
	assign push_set.xb     = meta_s4.xb;
	assign push_set.y      = meta_s4.y;
	assign push_set.ya     = meta_s4.ya;
	assign push_set.want_a = meta_s4.want_a;
	assign push_set.want_b = meta_s4.want_b;
	assign push_set.want_c = meta_s4.want_c;
	assign push_set.edge_a = mv_a > threshold;
	assign push_set.edge_b = d_pc_s4 > threshold;

	assign inflight = ndem_pkg::IFW'($countones({v_s1, v_s2, v_s3, v_s4}));

endmodule

>>> rtl/core/ndem_out_queue.sv
// ----------------------------------------------------------------------------
// ndem_out_queue
// Result set queue with credit check, serializer and output register.
// ----------------------------------------------------------------------------
module ndem_out_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  ndem_pkg::set_t                    push_set,
	input  logic [ndem_pkg::IFW-1:0]          inflight,
	output logic                              room,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic                              edge_res,
	output logic [ndem_pkg::OUT_X_W-1:0]      out_x,
	output logic [ndem_pkg::HEIGHT_W-1:0]     out_y,
	output logic                              run_last
);

	ndem_pkg::set_t             fifo_q [ndem_pkg::QDEPTH];
	logic [ndem_pkg::QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [ndem_pkg::QCW-1:0]   cnt_q;
	logic [2:0]                 done_q;

	ndem_pkg::set_t             head;
	logic                       head_ok;
	logic [2:0]                 rem, sel;
	logic                       last, load, pop;
	logic [ndem_pkg::QCW:0]     used;

	logic                       out_valid_q, edge_q, run_last_q;
	logic [ndem_pkg::OUT_X_W-1:0]  x_q;
	logic [ndem_pkg::HEIGHT_W-1:0] y_q;

	assign head    = fifo_q[rd_ptr_q];
	assign head_ok = cnt_q != '0;
	assign rem     = {head.want_c, head.want_b, head.want_a} & ~done_q;

	always_comb begin
		if (rem[0]) begin
			sel = 3'b001;
		end else if (rem[1]) begin
			sel = 3'b010;
		end else begin
			sel = 3'b100;
		end
	end

	assign last = (rem & ~sel) == 3'b000;
	assign load = head_ok && (!out_valid_q || !out_stall);
	assign pop  = load && last;

	assign used = (ndem_pkg::QCW+1)'(cnt_q) + (ndem_pkg::QCW+1)'(inflight);
	assign room = used < (ndem_pkg::QCW+1)'(ndem_pkg::QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			done_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + ndem_pkg::QCW'(push) - ndem_pkg::QCW'(pop);
			if (load) begin
				done_q <= last ? 3'b000 : (done_q | sel);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_last_q <= last;
			if (sel[0]) begin
				edge_q <= head.edge_a;
				x_q    <= head.xa;
				y_q    <= head.ya;
			end else if (sel[1]) begin
				edge_q <= head.edge_b;
				x_q    <= head.xb;
				y_q    <= head.y;
			end else begin
				edge_q <= 1'b0;
				x_q    <= head.xa;
				y_q    <= head.y;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign edge_res  = edge_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign run_last  = run_last_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < ndem_pkg::QCW'(ndem_pkg::QDEPTH)))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("result queue underflow");

	a_set_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		head_ok |-> (rem != 3'b000))
		else $error("queued result set has nothing left to send");

endmodule

>>> rtl/core/neighbor_delta_edge_mask.sv
// ----------------------------------------------------------------------------
// neighbor_delta_edge_mask
// Forward-difference edge mask over a raster ARGB pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while its result queue has room and
// flags each pixel of the row above against its right neighbor and the pixel
// below, using one row memory with one write and one read per pixel; the
// right neighbor is fetched one column ahead. Results pass from the difference
// pipeline through the queue and leave one per clock through a single output
// register unless the output stalls, so in every row but the last the block
// sustains one pixel per clock, while the last row, with two results per pixel
// (one on the first, three on the last), runs slower. An eight-entry result
// queue absorbs output stalls. The row memory is not cleared after reset.
// ----------------------------------------------------------------------------
module neighbor_delta_edge_mask #(
	parameter int MAX_WIDTH = ndem_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ndem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ndem_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         red,
	input  logic [7:0]                         green,
	input  logic [7:0]                         blue,
	input  logic [7:0]                         alpha,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               edge_res,
	output logic [ndem_pkg::OUT_X_W-1:0]       out_x,
	output logic [ndem_pkg::HEIGHT_W-1:0]      out_y,
	output logic                               run_last
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int LW = (XW + 1 > ndem_pkg::WIDTH_REG_W) ? XW + 1 : ndem_pkg::WIDTH_REG_W;

	logic [ndem_pkg::WIDTH_REG_W-1:0] width_q;
	logic [ndem_pkg::HEIGHT_W-1:0]    height_q;
	logic [ndem_pkg::THR_W-1:0]       thr_q;
	logic                             amode_q;

	logic [XW-1:0]                    col_q;
	logic [ndem_pkg::HEIGHT_W-1:0]    row_q;
	logic [ndem_pkg::PIX_W-1:0]       prev_q;
	logic [ndem_pkg::PIX_W-1:0]       ahead_q;
	logic                             rd_pend_q;

	logic [LW-1:0]                    w_ext, w_eff, col_lim;
	logic [ndem_pkg::HEIGHT_W-1:0]    h_eff, row_lim;
	logic                             last_col, last_row;
	logic                             accept, room;
	logic [ndem_pkg::PIX_W-1:0]       cur, rdata, above_fwd;
	logic [XW-1:0]                    raddr;
	ndem_pkg::meta_t                  meta;

	logic                             push;
	ndem_pkg::set_t                   push_set;
	logic [ndem_pkg::IFW-1:0]         inflight;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ndem_pkg::WIDTH_RST;
			height_q <= ndem_pkg::HEIGHT_RST;
			thr_q    <= ndem_pkg::THR_RST;
			amode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ndem_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[ndem_pkg::WIDTH_REG_W-1:0];
				ndem_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[ndem_pkg::HEIGHT_W-1:0];
				ndem_pkg::REG_THRESHOLD:    thr_q    <= cfg_data[ndem_pkg::THR_W-1:0];
				ndem_pkg::REG_ALPHA_MODE:   amode_q  <= cfg_data[0];
			endcase
		end
	end

	// effective frame size
	always_comb begin
		w_ext = LW'(width_q);
		if (w_ext < LW'(2)) begin
			w_eff = LW'(2);
		end else if (w_ext > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		col_lim = w_eff - LW'(1);
		h_eff   = (height_q < 16'd2) ? 16'd2 : height_q;
		row_lim = h_eff - 16'd1;
	end

	assign last_col = LW'(col_q) >= col_lim;
	assign last_row = row_q >= row_lim;

	assign in_stall = !room;
	assign accept   = in_valid && room;
	assign cur      = {alpha, red, green, blue};

	// next read is the right neighbor of the pixel above, or column 0 at row end
	assign raddr     = last_col ? '0 : (col_q + XW'(1));
	assign above_fwd = rd_pend_q ? rdata : ahead_q;

	assign meta.xa        = ndem_pkg::OUT_X_W'(col_q);
	assign meta.xb        = ndem_pkg::OUT_X_W'(col_q - XW'(1));
	assign meta.y         = row_q;
	assign meta.ya        = row_q - 16'd1;
	assign meta.want_a    = row_q != '0;
	assign meta.want_b    = last_row && (col_q != '0);
	assign meta.want_c    = last_row && last_col;
	assign meta.use_right = !last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			prev_q    <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= accept;
			if (accept) begin
				prev_q <= cur;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : (row_q + 16'd1);
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			ahead_q <= rdata;
		end
	end

	ndem_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (cur),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	ndem_diff u_diff (
		.clk        (clk),
		.arst_n     (arst_n),
		.alpha_mode (amode_q),
		.threshold  (thr_q),
		.start      (accept),
		.cur        (cur),
		.prev       (prev_q),
		.above      (above_fwd),
		.meta       (meta),
		.right      (rdata),
		.push       (push),
		.push_set   (push_set),
		.inflight   (inflight)
	);

	ndem_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_set  (push_set),
		.inflight  (inflight),
		.room      (room),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.edge_res  (edge_res),
		.out_x     (out_x),
		.out_y     (out_y),
		.run_last  (run_last)
	);

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(col_q) <= LW'(MAX_WIDTH - 1))
		else $error("column counter beyond row memory");

endmodule

>>> test/neighbor_delta_edge_mask_tb.sv
// ----------------------------------------------------------------------------
// neighbor_delta_edge_mask_tb
// Self-checking bench for the forward-difference edge mask block.
// ----------------------------------------------------------------------------
// Streams raster ARGB frames through the block and predicts each edge flag
// from its own copy of the line buffer, counters and registers. A short
// directed part covers channel extremes, both compare modes, saturated
// sizes and a size shrunk in the middle of a frame; random frames follow
// under three idling mixes, with one long output hold-off and one width
// setting above the row memory. Results are checked field by field in order.
// ----------------------------------------------------------------------------
module neighbor_delta_edge_mask_tb;

	localparam int MAX_W         = ndem_pkg::MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_PIXELS  = 100;

	typedef struct packed {
		logic        edge_flag;
		logic [11:0] x;
		logic [15:0] y;
		logic        last;
	} mask_result_t;

	class edge_mask_scoreboard;
		logic [31:0]  row_mem [MAX_W];
		logic [31:0]  prev_px;
		int unsigned  col_count;
		int unsigned  row_idx;
		logic [12:0]  width_reg;
		logic [15:0]  height_reg;
		logic [7:0]   threshold_reg;
		logic         alpha_only;
		mask_result_t pending_flags [$];
		int           mismatches;
		int           pixels_seen;
		int           results_seen;
		int           edges_seen;

		function new();
			prev_px       = '0;
			col_count     = 0;
			row_idx       = 0;
			width_reg     = ndem_pkg::WIDTH_RST;
			height_reg    = ndem_pkg::HEIGHT_RST;
			threshold_reg = ndem_pkg::THR_RST;
			alpha_only    = 1'b0;
			mismatches    = 0;
			pixels_seen   = 0;
			results_seen  = 0;
			edges_seen    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				ndem_pkg::REG_IMAGE_WIDTH:  width_reg = value[12:0];
				ndem_pkg::REG_IMAGE_HEIGHT: height_reg = value;
				ndem_pkg::REG_THRESHOLD:    threshold_reg = value[7:0];
				ndem_pkg::REG_ALPHA_MODE:   alpha_only = value[0];
				default: ;
			endcase
		endfunction

		// mean premultiplied channel distance, or plain alpha distance
		function logic [7:0] pair_delta(logic [31:0] s, logic [31:0] d);
			int unsigned sum, ps, pd;
			int k;
			if (alpha_only)
				return (s[31:24] > d[31:24]) ? s[31:24] - d[31:24] : d[31:24] - s[31:24];
			sum = 0;
			for (k = 0; k < 3; k++) begin
				ps = 32'(s[8*k +: 8]) * 32'(s[31:24]);
				pd = 32'(d[8*k +: 8]) * 32'(d[31:24]);
				sum += ((ps > pd) ? ps - pd : pd - ps) / 255;
			end
			return 8'(sum / 3);
		endfunction

		function void note_pixel(logic [31:0] cur);
			int unsigned  w, h, x, y;
			bit           last_col, last_row;
			logic [7:0]   mv, v;
			mask_result_t res [3];
			int           n;
			w = width_reg;
			h = height_reg;
			if (w < 2) w = 2;
			if (w > MAX_W) w = MAX_W;
			if (h < 2) h = 2;
			x = col_count;
			y = row_idx;
			last_col = (x >= w - 1);
			last_row = (y >= h - 1);
			n = 0;
			pixels_seen++;
			if (y >= 1) begin
				mv = '0;
				if (!last_col)
					mv = pair_delta(row_mem[x], row_mem[x + 1]);
				v = pair_delta(row_mem[x], cur);
				if (v > mv) mv = v;
				res[n] = '{mv > threshold_reg, 12'(x), 16'(y - 1), 1'b0};
				n++;
			end
			if (last_row && x >= 1) begin
				res[n] = '{pair_delta(prev_px, cur) > threshold_reg, 12'(x - 1), 16'(y), 1'b0};
				n++;
			end
			if (last_row && last_col) begin
				res[n] = '{1'b0, 12'(x), 16'(y), 1'b0};
				n++;
			end
			if (n > 0) res[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++)
				pending_flags.push_back(res[i]);
			row_mem[x] = cur;
			prev_px = cur;
			if (last_col) begin
				col_count = 0;
				row_idx = last_row ? 0 : ((y + 1) & 32'hFFFF);
			end else begin
				col_count = x + 1;
			end
		endfunction

		function void check_result(logic e, logic [11:0] x, logic [15:0] y, logic last);
			mask_result_t want;
			results_seen++;
			if (e === 1'b1) edges_seen++;
			if (pending_flags.size() == 0) begin
				$error("result with none pending: x %0d y %0d", x, y);
				mismatches++;
				return;
			end
			want = pending_flags.pop_front();
			if (e !== want.edge_flag) begin
				$error("edge_res: expected %0d, actual %0d", want.edge_flag, e);
				mismatches++;
			end
			if (x !== want.x) begin
				$error("out_x: expected %0d, actual %0d", want.x, x);
				mismatches++;
			end
			if (y !== want.y) begin
				$error("out_y: expected %0d, actual %0d", want.y, y);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("run_last: expected %0d, actual %0d", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ndem_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ndem_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic [7:0] alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic edge_res;
	logic [ndem_pkg::OUT_X_W-1:0] out_x;
	logic [ndem_pkg::HEIGHT_W-1:0] out_y;
	logic run_last;

	edge_mask_scoreboard sb = new();
	int send_idle_pct = 7;
	int recv_idle_pct = 69;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int pixels_sent = 0;
	int frames_sent = 0;
	logic [31:0] last_px = '0;

	neighbor_delta_edge_mask dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.edge_res(edge_res),
		.out_x(out_x),
		.out_y(out_y),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	// results first, then the request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(edge_res, out_x, out_y, run_last);
			if (in_valid && !in_stall)
				sb.note_pixel({alpha, red, green, blue});
		end
	end

	// a toggle of hold_req starts a long hold-off
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		int unsigned kind;
		kind = $urandom_range(9);
		p = $urandom();
		if (kind >= 5 && kind < 7)
			p = {{8{p[0]}}, {8{p[1]}}, {8{p[2]}}, {8{p[3]}}};
		else if (kind >= 7)
			p = last_px ^ (p & 32'h0307_0307);
		last_px = p;
		return p;
	endfunction

	task automatic send_pixel(input logic [31:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		alpha <= p[31:24];
		red <= p[23:16];
		green <= p[15:8];
		blue <= p[7:0];
		do @(posedge clk); while (in_stall);
		pixels_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	// block must be idle: all results in and the pipeline flushed
	task automatic begin_setup(input logic [15:0] w, h, t, input logic am);
		while (sb.pending_flags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ndem_pkg::REG_IMAGE_WIDTH, w);
		write_reg(ndem_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(ndem_pkg::REG_THRESHOLD, t);
		write_reg(ndem_pkg::REG_ALPHA_MODE, {15'b0, am});
		cfg_we <= 1'b0;
	endtask

	task automatic run_frame(input logic [15:0] w, h, t, input logic am, input bit hold);
		int unsigned ew, eh;
		ew = w[12:0];
		if (ew < 2) ew = 2;
		if (ew > MAX_W) ew = MAX_W;
		eh = h;
		if (eh < 2) eh = 2;
		begin_setup(w, h, t, am);
		if (hold) hold_req <= ~hold_req;
		repeat (ew * eh) send_pixel(random_pixel());
		in_valid <= 1'b0;
		frames_sent++;
	endtask

	initial begin
		logic [15:0] w, h, t;
		logic am;
		int target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// channel extremes, premultiplied colour, zero threshold
		begin_setup(16'd3, 16'd3, 16'd0, 1'b0);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFF00_0000);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'hFFFF_0000);
		send_pixel(32'hFF00_FF00);
		send_pixel(32'hFF00_00FF);
		send_pixel(32'h8080_8080);
		send_pixel(32'h0101_0101);
		in_valid <= 1'b0;

		// alpha mode at top threshold: never an edge
		begin_setup(16'd2, 16'd2, 16'd255, 1'b1);
		send_pixel(32'hFF12_3456);
		send_pixel(32'h00AB_CDEF);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		in_valid <= 1'b0;

		// sizes below range saturate to two
		begin_setup(16'd0, 16'd1, 16'd254, 1'b1);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'hFF00_0000);
		send_pixel(32'hFF00_0000);
		send_pixel(32'h00FF_FFFF);
		in_valid <= 1'b0;

		// tallest height, then both sizes shrunk under the running counters
		begin_setup(16'd3, 16'd65535, 16'd30, 1'b0);
		repeat (8) send_pixel(random_pixel());
		in_valid <= 1'b0;
		begin_setup(16'd2, 16'd2, 16'd30, 1'b0);
		send_pixel(random_pixel());
		in_valid <= 1'b0;
		frames_sent += 4;

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 69 : 0;
			recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 7 : 0;
			if (ph == 2) begin
				run_frame(16'd8, 16'd12, 16'd20, 1'b0, 1'b1);
				// width above the row memory, then shrunk to finish the frame
				begin_setup(16'hFFFF, 16'd0, 16'($urandom_range(40)), 1'b0);
				repeat (6) send_pixel(random_pixel());
				in_valid <= 1'b0;
				begin_setup(16'd2, 16'd2, 16'd20, 1'b0);
				repeat (3) send_pixel(random_pixel());
				in_valid <= 1'b0;
				frames_sent++;
			end
			target = pixels_sent + PHASE_PIXELS;
			while (pixels_sent < target) begin
				w = ($urandom_range(6) == 0) ? 16'($urandom_range(10, 40))
					: 16'($urandom_range(2, 9));
				h = 16'($urandom_range(2, 6));
				if ($urandom_range(9) == 0) w = 16'($urandom_range(1));
				if ($urandom_range(9) == 0) h = 16'($urandom_range(1));
				case ($urandom_range(7))
					0: t = 16'd0;
					1: t = 16'd255;
					default: t = 16'($urandom_range(50));
				endcase
				am = $urandom_range(1);
				run_frame(w, h, t, am, 1'b0);
			end
		end

		while (sb.pending_flags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d pixels over %0d frames, %0d results checked, %0d edges flagged",
			sb.pixels_seen, frames_sent, sb.results_seen, sb.edges_seen);
		$display("both compare modes, saturated and shrunk sizes, long hold-off");
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
